[hw/rtl/log_record_deframer_crc32_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the log record deframer
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef LOG_RECORD_DEFRAMER_CRC32_DEFINES_SVH
`define LOG_RECORD_DEFRAMER_CRC32_DEFINES_SVH

// Same-cycle implication.
`define LRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lrd_pkg.sv]
// ---------------------------------------------------------------------------
// Log record deframer package
// Record phases, stop codes, framing constants and the CRC-32 byte update.
// ---------------------------------------------------------------------------
package lrd_pkg;

  localparam logic [7:0]  MarkerByte = 8'hAB;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcOnes    = 32'hFFFFFFFF;

  typedef enum logic [12:0] {
    PH_MARK = 13'b0000000000001,
    PH_KLO  = 13'b0000000000010,
    PH_KHI  = 13'b0000000000100,
    PH_KEY  = 13'b0000000001000,
    PH_V0   = 13'b0000000010000,
    PH_V1   = 13'b0000000100000,
    PH_V2   = 13'b0000001000000,
    PH_V3   = 13'b0000010000000,
    PH_VAL  = 13'b0000100000000,
    PH_C0   = 13'b0001000000000,
    PH_C1   = 13'b0010000000000,
    PH_C2   = 13'b0100000000000,
    PH_C3   = 13'b1000000000000
  } phase_e;

  typedef enum logic [1:0] {
    STOP_NONE   = 2'd0,
    STOP_MARKER = 2'd1,
    STOP_CRC    = 2'd2,
    STOP_TRUNC  = 2'd3
  } stop_code_e;

  // Reflected CRC-32 update by one byte, bit by bit.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

[hw/rtl/lrd_in_if.sv]
// ---------------------------------------------------------------------------
// Log byte channel
// Valid/ready channel carrying one log byte and its end-of-log flag.
// ---------------------------------------------------------------------------
interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] log_byte;
  logic       end_of_log;

  modport source (output valid, output log_byte, output end_of_log, input ready);
  modport sink   (input valid, input log_byte, input end_of_log, output ready);
endinterface

[hw/rtl/lrd_out_if.sv]
// ---------------------------------------------------------------------------
// Deframer result channel
// Valid/ready channel carrying payload bytes and record status.
// ---------------------------------------------------------------------------
interface lrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       is_value;
  logic       record_done;
  logic [1:0] stop_code;
  logic       halted;

  modport source (output valid, output payload_byte, output payload_valid,
                  output is_value, output record_done, output stop_code,
                  output halted, input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input is_value, input record_done, input stop_code,
                  input halted, output ready);
endinterface

[hw/rtl/log_record_deframer_crc32.sv]
// A result is registered onto out_o in the cycle after its log byte is accepted.
// One log byte per cycle while out_o is not stalled; the byte-wide CRC-32 update and the
// length counter settle combinationally between the state and result registers.
// Reset clears the phase to expect a marker, the CRC to all ones, the counters,
// the stop flag and the result valid; after a stop, bytes are taken and dropped.
// ---------------------------------------------------------------------------
// Log record deframer with CRC-32 check
// Parses marker, lengths, key, value and CRC of each record and reports
// payload bytes and record status on a registered result channel.
// ---------------------------------------------------------------------------
`include "log_record_deframer_crc32_defines.svh"

module log_record_deframer_crc32
  import lrd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  lrd_in_if.sink    in_i,
  lrd_out_if.source out_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] count_q, count_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] stored_q, stored_d;
  logic        stopped_q;

  logic        out_valid_q;
  logic [7:0]  pb_q;
  logic        pv_q, iv_q, done_q;
  stop_code_e  code_q;

  logic        in_fire;
  logic [7:0]  b;
  logic [31:0] crc_upd;
  logic [31:0] cnt_dec;
  logic [31:0] crc_full;
  logic [7:0]  pb;
  logic        pv, iv, done;
  stop_code_e  code;
  logic        res_valid;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign b          = in_i.log_byte;
  assign crc_upd    = crc32_byte(crc_q, b);
  assign cnt_dec    = count_q - 32'd1;
  assign crc_full   = {b, stored_q[23:0]};

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    crc_d    = crc_q;
    stored_d = stored_q;
    pb       = 8'd0;
    pv       = 1'b0;
    iv       = 1'b0;
    done     = 1'b0;
    code     = STOP_NONE;
    case (phase_q)
      PH_KLO: begin
        crc_d   = crc_upd;
        count_d = {24'd0, b};
        phase_d = PH_KHI;
      end
      PH_KHI: begin
        crc_d   = crc_upd;
        count_d = {16'd0, b, count_q[7:0]};
        phase_d = ({b, count_q[7:0]} != 16'd0) ? PH_KEY : PH_V0;
      end
      PH_KEY: begin
        crc_d   = crc_upd;
        pb      = b;
        pv      = 1'b1;
        count_d = cnt_dec;
        if (cnt_dec == 32'd0) begin
          phase_d = PH_V0;
        end
      end
      PH_V0: begin
        crc_d   = crc_upd;
        count_d = {24'd0, b};
        phase_d = PH_V1;
      end
      PH_V1: begin
        crc_d   = crc_upd;
        count_d = {16'd0, b, count_q[7:0]};
        phase_d = PH_V2;
      end
      PH_V2: begin
        crc_d   = crc_upd;
        count_d = {8'd0, b, count_q[15:0]};
        phase_d = PH_V3;
      end
      PH_V3: begin
        crc_d   = crc_upd;
        count_d = {b, count_q[23:0]};
        phase_d = ({b, count_q[23:0]} != 32'd0) ? PH_VAL : PH_C0;
      end
      PH_VAL: begin
        crc_d   = crc_upd;
        pb      = b;
        pv      = 1'b1;
        iv      = 1'b1;
        count_d = cnt_dec;
        if (cnt_dec == 32'd0) begin
          phase_d = PH_C0;
        end
      end
      PH_C0: begin
        stored_d = {24'd0, b};
        phase_d  = PH_C1;
      end
      PH_C1: begin
        stored_d = {16'd0, b, stored_q[7:0]};
        phase_d  = PH_C2;
      end
      PH_C2: begin
        stored_d = {8'd0, b, stored_q[15:0]};
        phase_d  = PH_C3;
      end
      PH_C3: begin
        stored_d = crc_full;
        done     = 1'b1;
        if ((crc_q ^ CrcOnes) != crc_full) begin
          code = STOP_CRC;
        end
        phase_d = PH_MARK;
      end
      default: begin
        // Expecting a marker; any other phase code is handled the same way.
        phase_d = PH_MARK;
        if (b != MarkerByte) begin
          code = STOP_MARKER;
        end else begin
          crc_d    = CrcOnes;
          count_d  = 32'd0;
          stored_d = 32'd0;
          phase_d  = PH_KLO;
        end
      end
    endcase
    if (code == STOP_NONE && in_i.end_of_log && phase_d != PH_MARK) begin
      code = STOP_TRUNC;
    end
  end

  assign res_valid = !stopped_q && (pv || done || code != STOP_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MARK;
      count_q   <= 32'd0;
      crc_q     <= CrcOnes;
      stored_q  <= 32'd0;
      stopped_q <= 1'b0;
    end else if (in_fire && !stopped_q) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      crc_q     <= crc_d;
      stored_q  <= stored_d;
      stopped_q <= (code != STOP_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pb_q   <= pb;
      pv_q   <= pv;
      iv_q   <= iv;
      done_q <= done;
      code_q <= code;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.payload_byte  = pb_q;
  assign out_o.payload_valid = pv_q;
  assign out_o.is_value      = iv_q;
  assign out_o.record_done   = done_q;
  assign out_o.stop_code     = code_q;
  assign out_o.halted        = (code_q != STOP_NONE);

  `LRD_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_q), "Phase register is not one-hot.")
  `LRD_ASSERT_NOW(a_no_result_when_stopped, stopped_q, !res_valid, "Result produced after stop.")
  `LRD_ASSERT_NEXT(a_stop_latches, in_fire && res_valid && code != STOP_NONE, stopped_q,
    "Stop did not latch.")
  `LRD_ASSERT_NEXT(a_done_to_marker, in_fire && res_valid && done, phase_q == PH_MARK,
    "Record end did not return to marker phase.")
  `LRD_ASSERT_NEXT(a_key_end_to_vlen,
    in_fire && !stopped_q && phase_q == PH_KEY && count_q == 32'd1,
    phase_q == PH_V0, "Key end did not move to value length.")

endmodule
